/* design/rfls_pkg.sv */
// rfls_pkg: shared types, codes and constants of the slot responder
package rfls_pkg;

    // request codes carried in req_type
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_OPEN   = 2'd1;
    localparam logic [1:0] REQ_RESULT = 2'd2;

    // send_kind codes
    localparam logic [1:0] SEND_NONE   = 2'd0;
    localparam logic [1:0] SEND_LOADED = 2'd1;
    localparam logic [1:0] SEND_RESEND = 2'd2;

    // dispatch codes
    localparam logic [1:0] DISP_NONE = 2'd0;
    localparam logic [1:0] DISP_PAIR = 2'd1;
    localparam logic [1:0] DISP_KEY  = 2'd2;

    // link_event codes
    localparam logic [1:0] LINK_NONE = 2'd0;
    localparam logic [1:0] LINK_UP   = 2'd1;
    localparam logic [1:0] LINK_DOWN = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_WINDOW_LIMIT = 2'd0;
    localparam logic [1:0] CFG_PAIR_CODE    = 2'd1;
    localparam logic [1:0] CFG_KEY_CODE     = 2'd2;

    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned EXT_W      = 26;
    localparam int unsigned LOST_W     = 6;

    localparam logic [7:0]        MAX_PAYLOAD    = 8'd32;
    localparam logic [EXT_W-1:0]  FIRST_EXT      = 26'd100;
    localparam logic [LOST_W-1:0] LATE_LOST      = 6'd35;
    localparam logic [LOST_W-1:0] STOP_LOST      = 6'd50;
    localparam logic [7:0]        POLL_IDX_RESET = 8'hff;

    localparam logic [23:0] RST_WINDOW_LIMIT = 24'd6000;
    localparam logic [7:0]  RST_PAIR_CODE    = 8'd1;
    localparam logic [7:0]  RST_KEY_CODE     = 8'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  frame_type;
        logic [7:0]  item_length;
        logic [7:0]  poll_index;
        logic [23:0] base_timeout_us;
        logic        sync_held;
    } req_t;

    typedef struct packed {
        logic        too_big;
        logic [25:0] window_us;
        logic [1:0]  send_kind;
        logic [7:0]  send_type;
        logic [7:0]  send_length;
        logic        sync_start;
        logic        sync_early;
        logic        sync_early_late;
        logic        sync_stop;
        logic [1:0]  dispatch;
        logic [1:0]  link_event;
        logic        data_loaded;
    } rsp_t;

    typedef struct packed {
        logic [23:0] window_limit_us;
        logic [7:0]  pair_request_code;
        logic [7:0]  key_request_code;
    } cfg_t;

endpackage

/* design/rfls_chan_if.sv */
// rfls_chan_if: valid/ready channel carrying one payload per transfer
interface rfls_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/rfls_slot_ctrl.sv */
// rfls_slot_ctrl: link state registers and the per-request result logic
module rfls_slot_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  rfls_pkg::req_t   item,
    input  rfls_pkg::cfg_t   cfg,
    output rfls_pkg::rsp_t   rsp
);

    logic [rfls_pkg::EXT_W-1:0]  ext_reg, ext_next;
    logic [rfls_pkg::LOST_W-1:0] lost_reg, lost_next;
    logic [7:0]                  last_idx_reg, last_idx_next;
    logic                        link_up_reg, link_up_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [7:0]                  pend_type_reg, pend_type_next;
    logic [7:0]                  pend_len_reg, pend_len_next;
    logic [7:0]                  prev_type_reg, prev_type_next;
    logic [7:0]                  prev_len_reg, prev_len_next;

    logic [rfls_pkg::EXT_W-1:0]  ext_step;
    logic [rfls_pkg::LOST_W-1:0] lost_inc;

    // first miss starts the extension, later misses double it
    assign ext_step = (ext_reg == '0) ? rfls_pkg::FIRST_EXT
                                      : {ext_reg[rfls_pkg::EXT_W-2:0], 1'b0};
    assign lost_inc = lost_reg + 6'd1;

    always_comb
    begin
        ext_next        = ext_reg;
        lost_next       = lost_reg;
        last_idx_next   = last_idx_reg;
        link_up_next    = link_up_reg;
        pend_valid_next = pend_valid_reg;
        pend_type_next  = pend_type_reg;
        pend_len_next   = pend_len_reg;
        prev_type_next  = prev_type_reg;
        prev_len_next   = prev_len_reg;
        rsp             = '0;

        case (item.req_type)
            rfls_pkg::REQ_LOAD:
            begin
                if (item.item_length > rfls_pkg::MAX_PAYLOAD)
                begin
                    rsp.too_big = 1'b1;
                end
                else
                begin
                    pend_type_next  = item.frame_type;
                    pend_len_next   = item.item_length;
                    pend_valid_next = 1'b1;
                end
            end
            rfls_pkg::REQ_OPEN:
            begin
                rsp.window_us = {2'b00, item.base_timeout_us} + ext_reg;
            end
            rfls_pkg::REQ_RESULT:
            begin
                if (item.item_length == 8'd0)
                begin
                    if (!item.sync_held)
                    begin
                        ext_next = ext_step;
                        if (ext_step >= {2'b00, cfg.window_limit_us})
                        begin
                            ext_next        = '0;
                            pend_valid_next = 1'b0;
                            link_up_next    = 1'b0;
                            if (link_up_reg)
                                rsp.link_event = rfls_pkg::LINK_DOWN;
                        end
                    end
                    else
                    begin
                        lost_next            = lost_inc;
                        rsp.sync_early       = (lost_inc == 6'd1);
                        rsp.sync_early_late  = (lost_inc > rfls_pkg::LATE_LOST);
                        if (lost_inc > rfls_pkg::STOP_LOST)
                        begin
                            rsp.sync_stop = 1'b1;
                            ext_next      = '0;
                            lost_next     = '0;
                        end
                    end
                end
                else
                begin
                    rsp.sync_start = 1'b1;
                    ext_next       = '0;
                    lost_next      = '0;
                    if (item.poll_index == last_idx_reg)
                    begin
                        // repeated poll: answer with the frame sent last time
                        rsp.send_kind   = rfls_pkg::SEND_RESEND;
                        rsp.send_type   = prev_type_reg;
                        rsp.send_length = prev_len_reg;
                    end
                    else
                    begin
                        last_idx_next = item.poll_index;
                        if (item.frame_type == cfg.pair_request_code)
                            rsp.dispatch = rfls_pkg::DISP_PAIR;
                        else if (item.frame_type == cfg.key_request_code)
                            rsp.dispatch = rfls_pkg::DISP_KEY;
                        rsp.send_kind   = rfls_pkg::SEND_LOADED;
                        rsp.send_type   = pend_type_reg;
                        rsp.send_length = pend_len_reg;
                        prev_type_next  = pend_type_reg;
                        prev_len_next   = pend_len_reg;
                        pend_valid_next = 1'b0;
                        link_up_next    = 1'b1;
                        if (!link_up_reg)
                            rsp.link_event = rfls_pkg::LINK_UP;
                    end
                end
            end
            default:
            begin
            end
        endcase

        rsp.data_loaded = pend_valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg        <= '0;
            lost_reg       <= '0;
            last_idx_reg   <= rfls_pkg::POLL_IDX_RESET;
            link_up_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_type_reg  <= '0;
            pend_len_reg   <= '0;
            prev_type_reg  <= '0;
            prev_len_reg   <= '0;
        end
        else if (step)
        begin
            ext_reg        <= ext_next;
            lost_reg       <= lost_next;
            last_idx_reg   <= last_idx_next;
            link_up_reg    <= link_up_next;
            pend_valid_reg <= pend_valid_next;
            pend_type_reg  <= pend_type_next;
            pend_len_reg   <= pend_len_next;
            prev_type_reg  <= prev_type_next;
            prev_len_reg   <= prev_len_next;
        end
    end

endmodule

/* design/rf_link_slot_responder.sv */
// rf_link_slot_responder: top level of the polled radio link slot responder
//
// device-side link controller: each request transfer on req (load frame, open
// receive window, or receive result) produces exactly one result transfer on
// rsp. a request is registered on entry (in_data_reg), evaluated against the
// link state when the result stage can take it, and the result lands in an
// output register (out_data_reg). one request can be taken every cycle; the
// only limit is backpressure on rsp: while a finished result waits, the input
// register takes one more request and then holds ready low until rsp drains.
// configuration (window limit, pair and key request codes) is written through
// cfg_we/cfg_index/cfg_wdata and must only change while no request is in flight
module rf_link_slot_responder (
    input  logic                clk,
    input  logic                rst_n,
    rfls_chan_if.sink           req,
    rfls_chan_if.source         rsp,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_wdata
);

    // configuration registers
    rfls_pkg::cfg_t cfg_reg;

    // input stage
    logic           in_valid_reg, in_valid_next;
    rfls_pkg::req_t in_data_reg;

    // result stage
    logic           out_valid_reg, out_valid_next;
    rfls_pkg::rsp_t out_data_reg;

    rfls_pkg::rsp_t result;
    logic           advance;
    logic           step;
    logic           req_xfer;

    // result stage can take a new result when empty or being drained
    assign advance  = !out_valid_reg || rsp.ready;
    // request in the input stage is evaluated and its state update committed
    assign step     = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;
    assign req_xfer = req.valid && req.ready;

    assign in_valid_next  = req_xfer || (in_valid_reg && !advance);
    assign out_valid_next = step || (out_valid_reg && !rsp.ready);

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_limit_us   <= rfls_pkg::RST_WINDOW_LIMIT;
            cfg_reg.pair_request_code <= rfls_pkg::RST_PAIR_CODE;
            cfg_reg.key_request_code  <= rfls_pkg::RST_KEY_CODE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rfls_pkg::CFG_WINDOW_LIMIT: cfg_reg.window_limit_us   <= cfg_wdata;
                rfls_pkg::CFG_PAIR_CODE:    cfg_reg.pair_request_code <= cfg_wdata[7:0];
                rfls_pkg::CFG_KEY_CODE:     cfg_reg.key_request_code  <= cfg_wdata[7:0];
                default:
                begin
                    // writes to unused indexes are ignored
                end
            endcase
        end
    end

    // link state and per-request decisions
    rfls_slot_ctrl u_slot_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_data_reg),
        .cfg   (cfg_reg),
        .rsp   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_xfer)
            in_data_reg <= req.payload;
        if (step)
            out_data_reg <= result;
    end

endmodule
